// File: design/cpns_pkg.sv
// ============================================================================
// cpns_pkg: shared types and constants
// Widths, result codes and helpers for the curve point Newton step datapath.
// ============================================================================
package cpns_pkg;

    // Default pipeline shape
    localparam int DIM_DEFAULT        = 3;
    localparam int SQRT_STEPS_DEFAULT = 4;   // root bits resolved per sqrt stage
    localparam int DIV_STEPS_DEFAULT  = 2;   // quotient bits resolved per divider stage

    // Fixed field widths
    localparam int COMP_W   = 32;            // Q16.16 component
    localparam int COEF_W   = 64;            // Q35.29 coefficient
    localparam int SQ_IN_W  = 62;            // discriminant is below 2^62
    localparam int ROOT_W   = 31;
    localparam int STEP_W   = 32;
    localparam int QUOT_W   = 32;            // quotient bits below the overflow bit
    localparam int FRAC_W   = 16;

    // Register indexes
    localparam logic [0:0] REG_ABS_FLOOR     = 1'd0;
    localparam logic [0:0] REG_REL_TOL_SHIFT = 1'd1;

    // Result codes
    localparam logic [2:0] CASE_TINY    = 3'd0;
    localparam logic [2:0] CASE_DEGEN   = 3'd1;
    localparam logic [2:0] CASE_T1T3    = 3'd2;
    localparam logic [2:0] CASE_T1T2    = 3'd3;
    localparam logic [2:0] CASE_NEGDISC = 3'd4;
    localparam logic [2:0] CASE_QUAD    = 3'd5;

    localparam logic signed [STEP_W-1:0] STEP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [STEP_W-1:0] STEP_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COEF_W-1:0] t1;
        logic signed [COEF_W-1:0] t2;
        logic signed [COEF_W-1:0] t3;
        logic signed [COEF_W-1:0] t4;
    } coef_t;

    function automatic logic [COEF_W-1:0] mag64(input logic signed [COEF_W-1:0] x);
        logic [COEF_W-1:0] r;
        r = x[COEF_W-1] ? COEF_W'(-x) : COEF_W'(x);
        return r;
    endfunction

endpackage

// File: design/curve_point_newton_step.sv
// ============================================================================
// curve_point_newton_step: second-order Newton step, point to curve
// Forms the dot coefficients, classifies the case, solves the quadratic or
// falls back to a linear step, and returns a saturated Q16.16 step.
// ============================================================================
//
//  channel   dir  word layout (lsb first)                       handshake
//  s_*       in   diff xyz, first xyz, second xyz (9 x 32)      tvalid/tready
//  m_*       out  step[31:0], case_code[34:32], saturated[35]   tvalid/tready
//  cfg_*     in   index 0 abs_floor, index 1 rel_tol_shift      cfg_we, no wait
//
//  One word accepted per cycle unless m_* stalls. Stages: two coefficient
//  stages, six classify/scale stages, the square root pipeline, the divider
//  pipeline and the output register. The divider's long division sets the
//  depth, DIV_STEPS quotient bits per stage.
//  Reset clears all valid bits and loads register defaults.
//  A stall at m_* freezes every stage together; nothing is dropped or repeated.
//
module curve_point_newton_step #(
    parameter int DIM        = cpns_pkg::DIM_DEFAULT,
    parameter int SQRT_STEPS = cpns_pkg::SQRT_STEPS_DEFAULT,
    parameter int DIV_STEPS  = cpns_pkg::DIV_STEPS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // diff_x, diff_y, diff_z, first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // step, case_code, saturated, 4 zero bits
    output logic [39:0]  m_tdata
);

    localparam int SQ_ST   = (cpns_pkg::ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int DIV_LAT = (cpns_pkg::QUOT_W + DIV_STEPS - 1) / DIV_STEPS + 2;

    typedef struct packed {
        logic [2:0]         code;
        logic               sgz;
        logic               sgn;
        logic signed [31:0] s2;
        logic signed [31:0] s4;
        logic signed [63:0] t1;
        logic signed [63:0] linden;
    } sq_side_t;

    typedef struct packed {
        logic [2:0] code;
        logic       sgz;
        logic       sgn;
    } dv_side_t;

    // global advance: the pipe moves unless a finished word is held back
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- configuration ----------------
    logic [31:0] abs_floor_reg;
    logic [5:0]  shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_floor_reg <= 32'd1;
            shift_reg     <= 6'd33;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpns_pkg::REG_ABS_FLOOR:     abs_floor_reg <= cfg_data;
                cpns_pkg::REG_REL_TOL_SHIFT: shift_reg     <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // ---------------- A, B: products and dot sums ----------------
    logic [31:0]     vd [3];
    logic [31:0]     va [3];
    logic [31:0]     vb [3];
    cpns_pkg::coef_t coef;
    logic            a_valid_reg, b_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vd[i] = s_tdata[32*i +: 32];
            va[i] = s_tdata[96 + 32*i +: 32];
            vb[i] = s_tdata[192 + 32*i +: 32];
        end
    end

    cpns_coef #(
        .DIM (DIM)
    ) u_coef (
        .clk  (clk),
        .en   (en),
        .d    (vd),
        .a    (va),
        .b    (vb),
        .coef (coef)
    );

    // ---------------- C: magnitudes, maximum, sign of t1*t3 ----------------
    logic            c_valid_reg;
    cpns_pkg::coef_t c_t_reg;
    logic [63:0]     c_m_reg [4];
    logic [63:0]     c_tmax_reg;
    logic            c_sgz_reg, c_sgn_reg;

    always_ff @(posedge clk)
    begin
        logic [63:0] m [4];
        logic [63:0] mx;
        m[0] = cpns_pkg::mag64(coef.t1);
        m[1] = cpns_pkg::mag64(coef.t2);
        m[2] = cpns_pkg::mag64(coef.t3);
        m[3] = cpns_pkg::mag64(coef.t4);
        mx = m[0];
        for (int i = 1; i < 4; i++)
        begin
            if (m[i] > mx)
            begin
                mx = m[i];
            end
        end
        if (en)
        begin
            c_t_reg    <= coef;
            c_m_reg    <= m;
            c_tmax_reg <= mx;
            c_sgz_reg  <= (coef.t3 == '0) || (coef.t1 == '0);
            c_sgn_reg  <= coef.t1[63];
        end
    end

    // ---------------- D: tolerance, floor test, chunked leading one ----------------
    logic            d_valid_reg;
    cpns_pkg::coef_t d_t_reg;
    logic [63:0]     d_m_reg [4];
    logic [63:0]     d_lim_reg;
    logic            d_tiny_reg;
    logic [3:0]      d_nz_reg;
    logic [3:0]      d_pos_reg [4];
    logic            d_sgz_reg, d_sgn_reg;

    always_ff @(posedge clk)
    begin
        logic [3:0] pos [4];
        logic [3:0] nz;
        for (int c = 0; c < 4; c++)
        begin
            nz[c]  = |c_tmax_reg[16*c +: 16];
            pos[c] = '0;
            for (int b = 0; b < 16; b++)
            begin
                if (c_tmax_reg[16*c + b])
                begin
                    pos[c] = 4'(b);
                end
            end
        end
        if (en)
        begin
            d_t_reg    <= c_t_reg;
            d_m_reg    <= c_m_reg;
            d_lim_reg  <= c_tmax_reg >> shift_reg;
            d_tiny_reg <= c_tmax_reg < 64'(abs_floor_reg);
            d_nz_reg   <= nz;
            d_pos_reg  <= pos;
            d_sgz_reg  <= c_sgz_reg;
            d_sgn_reg  <= c_sgn_reg;
        end
    end

    // ---------------- E: case decision, scale shift ----------------
    logic               e_valid_reg;
    logic [2:0]         e_code_reg;
    logic signed [63:0] e_t1_reg, e_t2_reg, e_t4_reg, e_linden_reg;
    logic [5:0]         e_k_reg;
    logic               e_sgz_reg, e_sgn_reg;

    always_ff @(posedge clk)
    begin
        logic [2:0] code;
        logic [6:0] bits;
        if (d_tiny_reg)
        begin
            code = cpns_pkg::CASE_TINY;
        end
        else if (d_m_reg[3] < d_lim_reg)
        begin
            if (d_m_reg[1] < d_lim_reg)
            begin
                code = (d_m_reg[2] < d_lim_reg) ? cpns_pkg::CASE_DEGEN : cpns_pkg::CASE_T1T3;
            end
            else
            begin
                code = cpns_pkg::CASE_T1T2;
            end
        end
        else
        begin
            code = cpns_pkg::CASE_QUAD;
        end
        bits = '0;
        for (int c = 0; c < 4; c++)
        begin
            if (d_nz_reg[c])
            begin
                bits = 7'(16 * c) + 7'(d_pos_reg[c]) + 7'd1;
            end
        end
        if (en)
        begin
            e_code_reg   <= code;
            e_t1_reg     <= d_t_reg.t1;
            e_t2_reg     <= d_t_reg.t2;
            e_t4_reg     <= d_t_reg.t4;
            e_linden_reg <= (code == cpns_pkg::CASE_T1T2) ? d_t_reg.t2 : d_t_reg.t3;
            e_k_reg      <= (bits > 7'd30) ? 6'(bits - 7'd30) : 6'd0;
            e_sgz_reg    <= d_sgz_reg;
            e_sgn_reg    <= d_sgn_reg;
        end
    end

    // ---------------- F: scaled coefficients (floor shift) ----------------
    logic               f_valid_reg;
    logic [2:0]         f_code_reg;
    logic signed [31:0] f_s1_reg, f_s2_reg, f_s4_reg;
    logic signed [63:0] f_t1_reg, f_linden_reg;
    logic               f_sgz_reg, f_sgn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_code_reg   <= e_code_reg;
            f_s1_reg     <= 32'(e_t1_reg >>> e_k_reg);
            f_s2_reg     <= 32'(e_t2_reg >>> e_k_reg);
            f_s4_reg     <= 32'(e_t4_reg >>> e_k_reg);
            f_t1_reg     <= e_t1_reg;
            f_linden_reg <= e_linden_reg;
            f_sgz_reg    <= e_sgz_reg;
            f_sgn_reg    <= e_sgn_reg;
        end
    end

    // ---------------- G: discriminant products ----------------
    logic               g_valid_reg;
    logic signed [63:0] g_p22_reg, g_p41_reg;
    sq_side_t           g_side_reg;

    always_ff @(posedge clk)
    begin
        logic signed [63:0] p22, p41;
        p22 = f_s2_reg * f_s2_reg;
        p41 = f_s4_reg * f_s1_reg;
        if (en)
        begin
            g_p22_reg         <= p22;
            g_p41_reg         <= p41;
            g_side_reg.code   <= f_code_reg;
            g_side_reg.sgz    <= f_sgz_reg;
            g_side_reg.sgn    <= f_sgn_reg;
            g_side_reg.s2     <= f_s2_reg;
            g_side_reg.s4     <= f_s4_reg;
            g_side_reg.t1     <= f_t1_reg;
            g_side_reg.linden <= f_linden_reg;
        end
    end

    // ---------------- H: discriminant, final case ----------------
    logic                         h_valid_reg;
    logic [cpns_pkg::SQ_IN_W-1:0] h_sqin_reg;
    sq_side_t                     h_side_reg;

    always_ff @(posedge clk)
    begin
        logic signed [63:0] disc;
        sq_side_t           sd;
        disc = g_p22_reg - (g_p41_reg <<< 1);
        sd   = g_side_reg;
        if ((sd.code == cpns_pkg::CASE_QUAD) && disc[63])
        begin
            sd.code = cpns_pkg::CASE_NEGDISC;
        end
        if (en)
        begin
            h_sqin_reg <= disc[63] ? '0 : disc[cpns_pkg::SQ_IN_W-1:0];
            h_side_reg <= sd;
        end
    end

    // ---------------- square root ----------------
    logic [cpns_pkg::ROOT_W-1:0] sq;
    sq_side_t                    sq_side_reg [SQ_ST];
    logic [SQ_ST-1:0]            sq_valid_reg;

    cpns_isqrt #(
        .STEPS (SQRT_STEPS)
    ) u_isqrt (
        .clk  (clk),
        .en   (en),
        .val  (h_sqin_reg),
        .root (sq)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= h_side_reg;
            for (int i = 1; i < SQ_ST; i++)
            begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    // ---------------- dividers: two roots and the linear step ----------------
    sq_side_t           sq_out;
    logic signed [63:0] num5, num6, den4;
    logic signed [31:0] r5, r6, rl;
    logic               f5, f6, fl;
    dv_side_t           dv_side_reg [DIV_LAT];
    logic [DIV_LAT-1:0] dv_valid_reg;

    assign sq_out = sq_side_reg[SQ_ST-1];
    assign num5   = 64'(sq_out.s2) + 64'(sq);
    assign num6   = 64'(sq_out.s2) - 64'(sq);
    assign den4   = 64'(sq_out.s4);

    cpns_qdiv #(.STEPS (DIV_STEPS)) u_div5 (
        .clk (clk), .en (en), .num (num5), .den (den4), .step (r5), .sat (f5)
    );

    cpns_qdiv #(.STEPS (DIV_STEPS)) u_div6 (
        .clk (clk), .en (en), .num (num6), .den (den4), .step (r6), .sat (f6)
    );

    cpns_qdiv #(.STEPS (DIV_STEPS)) u_divl (
        .clk (clk), .en (en), .num (sq_out.t1), .den (sq_out.linden), .step (rl), .sat (fl)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= '{code: sq_out.code, sgz: sq_out.sgz, sgn: sq_out.sgn};
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            e_valid_reg  <= 1'b0;
            f_valid_reg  <= 1'b0;
            g_valid_reg  <= 1'b0;
            h_valid_reg  <= 1'b0;
            sq_valid_reg <= '0;
            dv_valid_reg <= '0;
        end
        else if (en)
        begin
            a_valid_reg  <= s_tvalid;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            d_valid_reg  <= c_valid_reg;
            e_valid_reg  <= d_valid_reg;
            f_valid_reg  <= e_valid_reg;
            g_valid_reg  <= f_valid_reg;
            h_valid_reg  <= g_valid_reg;
            sq_valid_reg <= {sq_valid_reg[SQ_ST-2:0], h_valid_reg};
            dv_valid_reg <= {dv_valid_reg[DIV_LAT-2:0], sq_valid_reg[SQ_ST-1]};
        end
    end

    // ---------------- output: root choice and result register ----------------
    dv_side_t           dv_out;
    logic signed [31:0] step_next;
    logic               sat_next;
    logic               out_valid_reg;
    logic signed [31:0] step_reg;
    logic [2:0]         code_reg;
    logic               sat_reg;

    assign dv_out = dv_side_reg[DIV_LAT-1];

    always_comb
    begin
        logic        pick5;
        logic [32:0] m5, m6, mm;
        m5    = r5[31] ? 33'(-33'(r5)) : 33'(r5);
        m6    = r6[31] ? 33'(-33'(r6)) : 33'(r6);
        pick5 = 1'b0;
        mm    = '0;
        step_next = '0;
        sat_next  = 1'b0;
        unique case (dv_out.code)
            cpns_pkg::CASE_TINY, cpns_pkg::CASE_DEGEN:
            begin
                step_next = '0;
                sat_next  = 1'b0;
            end
            cpns_pkg::CASE_T1T3, cpns_pkg::CASE_T1T2, cpns_pkg::CASE_NEGDISC:
            begin
                step_next = rl;
                sat_next  = fl;
            end
            cpns_pkg::CASE_QUAD:
            begin
                priority if (dv_out.sgz)
                begin
                    pick5 = m5 < m6;
                end
                else if (dv_out.sgn)
                begin
                    // want a non-positive step
                    priority if (r5 <= 0 && r6 <= 0) pick5 = r5 > r6;
                    else if (r5 <= 0)                  pick5 = 1'b1;
                    else if (r6 <= 0)                  pick5 = 1'b0;
                    else                               pick5 = r5 < r6;
                end
                else
                begin
                    priority if (r5 >= 0 && r6 >= 0) pick5 = r5 < r6;
                    else if (r5 >= 0)                  pick5 = 1'b1;
                    else if (r6 >= 0)                  pick5 = 1'b0;
                    else                               pick5 = r5 > r6;
                end
                step_next = pick5 ? r5 : r6;
                sat_next  = pick5 ? f5 : f6;
                if (dv_out.sgz)
                begin
                    // no preferred sign: magnitude, clipped at the top
                    mm = pick5 ? m5 : m6;
                    if (mm > 33'h0_7FFF_FFFF)
                    begin
                        step_next = cpns_pkg::STEP_MAX;
                        sat_next  = 1'b1;
                    end
                    else
                    begin
                        step_next = 32'(mm);
                    end
                end
            end
            default:
            begin
                step_next = '0;
                sat_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= step_next;
            code_reg <= dv_out.code;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, sat_reg, code_reg, step_reg};

    // ---------------- checks ----------------
    a_zero_cases: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (code_reg == cpns_pkg::CASE_TINY || code_reg == cpns_pkg::CASE_DEGEN)
        |-> step_reg == '0 && !sat_reg)
        else $error("zero-step case carries a step");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> code_reg <= cpns_pkg::CASE_QUAD)
        else $error("case code out of range");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sat_reg
        |-> step_reg == cpns_pkg::STEP_MAX || step_reg == cpns_pkg::STEP_MIN || step_reg == '0)
        else $error("saturated word with unclipped step");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_valid_reg) && $stable(h_valid_reg))
        else $error("pipeline moved during stall");

endmodule

// File: design/cpns_coef.sv
// ============================================================================
// cpns_coef: coefficient stages
// Products of the components (floored to Q32.29), then the four dot sums.
// ============================================================================
module cpns_coef #(
    parameter int DIM = cpns_pkg::DIM_DEFAULT
) (
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         d [3],
    input  logic [31:0]         a [3],
    input  logic [31:0]         b [3],
    output cpns_pkg::coef_t     coef
);

    localparam int NUSE = (DIM > 3) ? 3 : DIM;

    logic signed [60:0] pda_reg [3];
    logic signed [60:0] paa_reg [3];
    logic signed [60:0] pdb_reg [3];
    logic signed [60:0] pab_reg [3];
    logic signed [63:0] pda [3];
    logic signed [63:0] paa [3];
    logic signed [63:0] pdb [3];
    logic signed [63:0] pab [3];
    cpns_pkg::coef_t    coef_reg;
    cpns_pkg::coef_t    coef_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (i < NUSE)
            begin
                pda[i] = $signed(d[i]) * $signed(a[i]);
                paa[i] = $signed(a[i]) * $signed(a[i]);
                pdb[i] = $signed(d[i]) * $signed(b[i]);
                pab[i] = $signed(a[i]) * $signed(b[i]);
            end
            else
            begin
                pda[i] = '0;
                paa[i] = '0;
                pdb[i] = '0;
                pab[i] = '0;
            end
        end
    end

    // floor by 2^3: arithmetic shift
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pda_reg[i] <= 61'(pda[i] >>> 3);
                paa_reg[i] <= 61'(paa[i] >>> 3);
                pdb_reg[i] <= 61'(pdb[i] >>> 3);
                pab_reg[i] <= 61'(pab[i] >>> 3);
            end
        end
    end

    always_comb
    begin
        logic signed [63:0] sda, saa, sdb, sab;
        sda = 64'(pda_reg[0]) + 64'(pda_reg[1]) + 64'(pda_reg[2]);
        saa = 64'(paa_reg[0]) + 64'(paa_reg[1]) + 64'(paa_reg[2]);
        sdb = 64'(pdb_reg[0]) + 64'(pdb_reg[1]) + 64'(pdb_reg[2]);
        sab = 64'(pab_reg[0]) + 64'(pab_reg[1]) + 64'(pab_reg[2]);
        coef_next.t1 = sda;
        coef_next.t3 = saa;
        coef_next.t2 = saa - sdb;
        coef_next.t4 = -(sab <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// File: design/cpns_isqrt.sv
// ============================================================================
// cpns_isqrt: pipelined integer square root
// Floor square root, STEPS root bits resolved per register stage.
// ============================================================================
module cpns_isqrt #(
    parameter int STEPS = cpns_pkg::SQRT_STEPS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [cpns_pkg::SQ_IN_W-1:0]  val,
    output logic [cpns_pkg::ROOT_W-1:0]   root
);

    localparam int IW  = cpns_pkg::SQ_IN_W;
    localparam int RW  = cpns_pkg::ROOT_W;
    localparam int NST = (RW + STEPS - 1) / STEPS;

    logic [IW-1:0] rem_reg  [NST];
    logic [RW-1:0] root_reg [NST];

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        logic [IW-1:0] rem_in, rem_next;
        logic [RW-1:0] root_in, root_next;

        if (g == 0)
        begin : g_first
            assign rem_in  = val;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        always_comb
        begin
            int j;
            logic [63:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            for (int s = 0; s < STEPS; s++)
            begin
                j = RW - 1 - (g * STEPS + s);
                if (j >= 0)
                begin
                    // (r + 2^j)^2 - r^2 = r*2^(j+1) + 2^(2j)
                    trial = (64'(root_next) << (j + 1)) | (64'(1) << (2 * j));
                    if (64'(rem_next) >= trial)
                    begin
                        rem_next  = IW'(64'(rem_next) - trial);
                        root_next = root_next | (RW'(1) << j);
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
            end
        end
    end

    assign root = root_reg[NST-1];

endmodule

// File: design/cpns_qdiv.sv
// ============================================================================
// cpns_qdiv: pipelined Q16.16 divider
// Signed quotient truncated toward zero, saturated, zero divisor flagged.
// ============================================================================
module cpns_qdiv #(
    parameter int STEPS = cpns_pkg::DIV_STEPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [cpns_pkg::COEF_W-1:0]  num,
    input  logic signed [cpns_pkg::COEF_W-1:0]  den,
    output logic signed [cpns_pkg::STEP_W-1:0]  step,
    output logic                                sat
);

    localparam int W   = cpns_pkg::COEF_W;
    localparam int QW  = cpns_pkg::QUOT_W;
    localparam int FW  = cpns_pkg::FRAC_W;
    localparam int NST = (QW + STEPS - 1) / STEPS;

    typedef struct packed {
        logic neg;
        logic dz;
        logic nzero;
        logic nneg;
        logic ovf;
    } dflag_t;

    logic [W:0]    rem_reg  [NST+1];
    logic [QW-1:0] low_reg  [NST+1];
    logic [QW-1:0] q_reg    [NST+1];
    logic [W-1:0]  d_reg    [NST+1];
    dflag_t        flag_reg [NST+1];
    logic signed [cpns_pkg::STEP_W-1:0] step_reg;
    logic          sat_reg;

    // preparation: magnitudes and early overflow test
    always_ff @(posedge clk)
    begin
        logic [W-1:0] n, d;
        n = cpns_pkg::mag64(num);
        d = cpns_pkg::mag64(den);
        if (en)
        begin
            rem_reg[0]        <= {1'b0, n >> FW};
            low_reg[0]        <= {n[FW-1:0], {(QW-FW){1'b0}}};
            q_reg[0]          <= '0;
            d_reg[0]          <= d;
            flag_reg[0].neg   <= num[W-1] ^ den[W-1];
            flag_reg[0].dz    <= (d == '0);
            flag_reg[0].nzero <= (n == '0);
            flag_reg[0].nneg  <= num[W-1];
            flag_reg[0].ovf   <= ((n >> FW) >= d);
        end
    end

    for (genvar g = 0; g < NST; g++)
    begin : g_stage
        logic [W:0]    r_next;
        logic [QW-1:0] q_next;

        always_comb
        begin
            int idx;
            r_next = rem_reg[g];
            q_next = q_reg[g];
            for (int s = 0; s < STEPS; s++)
            begin
                idx = g * STEPS + s;
                if (idx < QW)
                begin
                    r_next = {r_next[W-1:0], low_reg[g][QW-1-idx]};
                    q_next = {q_next[QW-2:0], 1'b0};
                    if (r_next >= {1'b0, d_reg[g]})
                    begin
                        r_next    = r_next - {1'b0, d_reg[g]};
                        q_next[0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g+1]  <= r_next;
                q_reg[g+1]    <= q_next;
                low_reg[g+1]  <= low_reg[g];
                d_reg[g+1]    <= d_reg[g];
                flag_reg[g+1] <= flag_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [QW:0] q33;
        dflag_t      f;
        f   = flag_reg[NST];
        q33 = f.ovf ? {1'b1, {QW{1'b0}}} : {1'b0, q_reg[NST]};
        if (en)
        begin
            if (f.dz)
            begin
                sat_reg  <= 1'b1;
                step_reg <= f.nzero ? '0 : (f.nneg ? cpns_pkg::STEP_MIN : cpns_pkg::STEP_MAX);
            end
            else if (f.neg)
            begin
                if (q33 > 33'h0_8000_0000)
                begin
                    sat_reg  <= 1'b1;
                    step_reg <= cpns_pkg::STEP_MIN;
                end
                else
                begin
                    sat_reg  <= 1'b0;
                    step_reg <= 32'(-q33);
                end
            end
            else if (q33 > 33'h0_7FFF_FFFF)
            begin
                sat_reg  <= 1'b1;
                step_reg <= cpns_pkg::STEP_MAX;
            end
            else
            begin
                sat_reg  <= 1'b0;
                step_reg <= 32'(q33);
            end
        end
    end

    assign step = step_reg;
    assign sat  = sat_reg;

endmodule
